@@ rtl/core/oalt_pkg.sv @@
// Shared definitions for the ordered array list table.
// Holds field widths, operation codes, reset constants and the control structs.
// No dependencies.
package oalt_pkg;

   // Default sizing of the entry store.
   localparam int DEPTH_DEFAULT     = 16;
   localparam int WORD_BITS_DEFAULT = 32;

   // Fixed port field widths.
   localparam int KIND_BITS  = 3;
   localparam int POS_BITS   = 4;
   localparam int VALUE_BITS = 32;
   localparam int INDEX_BITS = 5;
   localparam int COUNT_BITS = 5;
   localparam int CAP_BITS   = 5;

   // Capacity register value after reset.
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   // Found index reported when nothing matches (minus one).
   localparam logic [INDEX_BITS-1:0] FOUND_NONE = 5'h1F;

   // Operation codes.
   localparam logic [KIND_BITS-1:0] KIND_APPEND = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_INSERT = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_DELETE = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_EDIT   = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_GET    = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_FIND   = 3'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the request fields
      logic decode;      // latch the reject decision
      logic do_append;   // write word at the end, count up
      logic do_edit;     // write word at position
      logic get_read;    // read entry at position
      logic ins_start;   // begin upward shift walk
      logic ins_step;    // one upward shift move
      logic ins_final;   // write word at position, count up
      logic dn_start;    // begin downward shift walk
      logic dn_step;     // one downward shift move
      logic del_commit;  // count down
      logic find_start;  // begin search walk
      logic find_step;   // one search compare
      logic load_rsp;    // load the result register
   } oalt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rejected;
      logic is_append;
      logic is_insert;
      logic is_delete;
      logic is_edit;
      logic is_get;
      logic is_find;
      logic del_none;    // deleting the last entry, nothing to move
      logic find_none;   // list is empty
      logic shift_last;  // current shift move is the final one
      logic find_hit;    // read word equals the search word
      logic find_last;   // current compare is on the last entry
      logic out_busy;    // result register holds an untaken result
   } oalt_status_type;

endpackage

@@ rtl/core/oalt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module oalt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/oalt_dpath.sv @@
// Datapath of the ordered array list table: operand latches, entry count,
// capacity register, entry store, walk index and result register.
// Depends on oalt_pkg and oalt_ram.
module oalt_dpath
   import oalt_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [KIND_BITS-1:0]         req_kind,
   input  logic [POS_BITS-1:0]          req_position,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic                         csr_valid,
   input  logic [CAP_BITS-1:0]          csr_capacity_in_use,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output logic signed [VALUE_BITS-1:0] rsp_read_data,
   output logic signed [INDEX_BITS-1:0] rsp_found_index,
   output logic [COUNT_BITS-1:0]        rsp_entry_count,
   output logic                         rsp_is_full,
   output logic                         rsp_is_empty,
   output logic                         rsp_status,
   input  oalt_cmd_type                 cmd,
   output oalt_status_type              status
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

   logic [KIND_BITS-1:0]  kind_ff;
   logic [POS_BITS-1:0]   pos_ff;
   logic [WORD_BITS-1:0]  word_ff;
   logic                  rej_ff, rej_in;
   logic [INDEX_BITS-1:0] found_ff, found_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CAP_BITS-1:0]   cap_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_read_data_ff;
   logic [INDEX_BITS-1:0] rsp_found_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic                  rsp_full_ff, rsp_empty_ff, rsp_status_ff;

   logic [CMP_W-1:0]      count_w, pos_w, idx_w, cap_raw, depth_w, cap_eff;
   logic                  full, occupied, rejected;

   logic                  wr_en, rd_en;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;
   logic [WORD_BITS-1:0]  wr_data, rd_data;

   // Operand latches, loaded when a request is accepted.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         pos_ff  <= req_position;
         word_ff <= WORD_BITS'(req_value);
      end
   end

   // Common-width copies for the range checks.
   assign count_w = CMP_W'(count_ff);
   assign pos_w   = CMP_W'(pos_ff);
   assign idx_w   = CMP_W'(idx_ff);
   assign cap_raw = CMP_W'(cap_ff);
   assign depth_w = CMP_W'(DEPTH);
   assign cap_eff = (cap_raw > depth_w) ? depth_w : cap_raw;

   assign full     = count_w >= cap_eff;
   assign occupied = pos_w < count_w;

   // Reject decision for the latched operation.
   always_comb begin
      case (kind_ff)
         KIND_APPEND:                    rejected = full;
         KIND_INSERT:                    rejected = full || !occupied;
         KIND_DELETE, KIND_EDIT, KIND_GET: rejected = !occupied;
         KIND_FIND:                      rejected = 1'b0;
         default:                        rejected = 1'b1;
      endcase
   end

   // Status toward the controller.
   always_comb begin
      status.rejected   = rejected;
      status.is_append  = kind_ff == KIND_APPEND;
      status.is_insert  = kind_ff == KIND_INSERT;
      status.is_delete  = kind_ff == KIND_DELETE;
      status.is_edit    = kind_ff == KIND_EDIT;
      status.is_get     = kind_ff == KIND_GET;
      status.is_find    = kind_ff == KIND_FIND;
      status.del_none   = (pos_w + CMP_W'(1)) == count_w;
      status.find_none  = count_w == '0;
      status.shift_last = (kind_ff == KIND_INSERT) ? (idx_w == (pos_w + CMP_W'(1)))
                                                   : ((idx_w + CMP_W'(2)) == count_w);
      status.find_hit   = rd_data == word_ff;
      status.find_last  = (idx_w + CMP_W'(1)) == count_w;
      status.out_busy   = rsp_valid_ff && rsp_stall;
   end

   // Store port selection and walk index update.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_data;
      rd_en   = 1'b0;
      rd_addr = idx_ff;
      idx_in  = idx_ff;
      if (cmd.do_append) begin
         wr_en   = 1'b1;
         wr_addr = ADDR_W'(count_ff);
         wr_data = word_ff;
      end
      if (cmd.do_edit || cmd.ins_final) begin
         wr_en   = 1'b1;
         wr_addr = ADDR_W'(pos_ff);
         wr_data = word_ff;
      end
      if (cmd.get_read) begin
         rd_en   = 1'b1;
         rd_addr = ADDR_W'(pos_ff);
      end
      if (cmd.ins_start) begin
         rd_en   = 1'b1;
         rd_addr = ADDR_W'(count_ff - CNT_W'(1));
         idx_in  = ADDR_W'(count_ff);
      end
      if (cmd.ins_step) begin
         wr_en = 1'b1;
         if (!status.shift_last) begin
            rd_en   = 1'b1;
            rd_addr = (idx_ff - ADDR_W'(1)) - ADDR_W'(1);
            idx_in  = idx_ff - ADDR_W'(1);
         end
      end
      if (cmd.dn_start) begin
         rd_en   = 1'b1;
         rd_addr = ADDR_W'(pos_ff) + ADDR_W'(1);
         idx_in  = ADDR_W'(pos_ff);
      end
      if (cmd.dn_step) begin
         wr_en = 1'b1;
         if (!status.shift_last) begin
            rd_en   = 1'b1;
            rd_addr = (idx_ff + ADDR_W'(1)) + ADDR_W'(1);
            idx_in  = idx_ff + ADDR_W'(1);
         end
      end
      if (cmd.find_start) begin
         rd_en   = 1'b1;
         rd_addr = '0;
         idx_in  = '0;
      end
      if (cmd.find_step && !status.find_hit && !status.find_last) begin
         rd_en   = 1'b1;
         rd_addr = idx_ff + ADDR_W'(1);
         idx_in  = idx_ff + ADDR_W'(1);
      end
   end

   oalt_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next values of the per-item status registers and the count.
   always_comb begin
      rej_in   = rej_ff;
      found_in = found_ff;
      count_in = count_ff;
      if (cmd.capture) begin
         rej_in   = 1'b0;
         found_in = FOUND_NONE;
      end
      if (cmd.decode) begin
         rej_in = rejected;
      end
      if (cmd.find_step && status.find_hit) begin
         found_in = INDEX_BITS'(idx_ff);
      end
      if (cmd.do_append || cmd.ins_final) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.del_commit) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rej_ff   <= rej_in;
      found_ff <= found_in;
      idx_ff   <= idx_in;
   end

   // Entry count and capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         count_ff <= count_in;
         if (csr_valid) begin
            cap_ff <= csr_capacity_in_use;
         end
      end
   end

   // Result register: set on load, cleared once the transfer completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_read_data_ff <= (status.is_get && !rej_ff) ? VALUE_BITS'(rd_data) : '0;
         rsp_found_ff     <= found_ff;
         rsp_count_ff     <= COUNT_BITS'(count_ff);
         rsp_full_ff      <= full;
         rsp_empty_ff     <= count_ff == '0;
         rsp_status_ff    <= rej_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_read_data_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_full     = rsp_full_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

@@ rtl/core/oalt_ctrl.sv @@
// Controller of the ordered array list table: sequences each operation
// through decode, store walks and result load. Depends on oalt_pkg.
module oalt_ctrl
   import oalt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  oalt_status_type status,
   output oalt_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_DECODE    = 3'd1;
   localparam logic [2:0] ST_INS_SHIFT = 3'd2;
   localparam logic [2:0] ST_INS_WRITE = 3'd3;
   localparam logic [2:0] ST_DEL_SHIFT = 3'd4;
   localparam logic [2:0] ST_FIND_SCAN = 3'd5;
   localparam logic [2:0] ST_FINISH    = 3'd6;

   logic [2:0] state_ff, state_in;

   // One operation at a time; new requests wait outside idle.
   assign req_stall = state_ff != ST_IDLE;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = ST_FINISH;
            if (status.rejected) begin
               state_in = ST_FINISH;
            end else if (status.is_append) begin
               cmd.do_append = 1'b1;
            end else if (status.is_edit) begin
               cmd.do_edit = 1'b1;
            end else if (status.is_get) begin
               cmd.get_read = 1'b1;
            end else if (status.is_insert) begin
               cmd.ins_start = 1'b1;
               state_in      = ST_INS_SHIFT;
            end else if (status.is_delete) begin
               if (status.del_none) begin
                  cmd.del_commit = 1'b1;
               end else begin
                  cmd.dn_start = 1'b1;
                  state_in     = ST_DEL_SHIFT;
               end
            end else if (status.is_find && !status.find_none) begin
               cmd.find_start = 1'b1;
               state_in       = ST_FIND_SCAN;
            end
         end
         ST_INS_SHIFT: begin
            cmd.ins_step = 1'b1;
            if (status.shift_last) begin
               state_in = ST_INS_WRITE;
            end
         end
         ST_INS_WRITE: begin
            cmd.ins_final = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_DEL_SHIFT: begin
            cmd.dn_step = 1'b1;
            if (status.shift_last) begin
               cmd.del_commit = 1'b1;
               state_in       = ST_FINISH;
            end
         end
         ST_FIND_SCAN: begin
            cmd.find_step = 1'b1;
            if (status.find_hit || status.find_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/ordered_array_list_table.sv @@
// Ordered array list table: append, insert, delete, edit, get and find on a
// list of signed words. Get, edit, append and rejected items go from decode
// straight to the result load; insert, delete and find first walk the store
// at one entry per cycle. A new request waits until the result of the last
// one is loaded. Reset empties the list and sets the capacity to 16; store
// contents stay.
module ordered_array_list_table
   import oalt_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [KIND_BITS-1:0]         req_kind,
   input  logic [POS_BITS-1:0]          req_position,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [VALUE_BITS-1:0] rsp_read_data,
   output logic signed [INDEX_BITS-1:0] rsp_found_index,
   output logic [COUNT_BITS-1:0]        rsp_entry_count,
   output logic                         rsp_is_full,
   output logic                         rsp_is_empty,
   output logic                         rsp_status,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CAP_BITS-1:0]          csr_capacity_in_use
);

   oalt_cmd_type    cmd;
   oalt_status_type status;

   // The capacity register takes a write in any cycle.
   assign csr_ready = 1'b1;

   oalt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   oalt_dpath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_kind            (req_kind),
      .req_position        (req_position),
      .req_value           (req_value),
      .csr_valid           (csr_valid && csr_ready),
      .csr_capacity_in_use (csr_capacity_in_use),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_read_data       (rsp_read_data),
      .rsp_found_index     (rsp_found_index),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_is_full         (rsp_is_full),
      .rsp_is_empty        (rsp_is_empty),
      .rsp_status          (rsp_status),
      .cmd                 (cmd),
      .status              (status)
   );

   // The store has one write port, so at most one write command per cycle.
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.do_append, cmd.do_edit, cmd.ins_step, cmd.dn_step, cmd.ins_final}))
      else $error("more than one store write in a cycle");

   // A result is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   // After a request transfer the block is busy with it.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while an operation is in progress");

endmodule
